FILE: src/csrgr_pkg.sv
// shared codes, state types and status struct for the csr graph reachability block
package csrgr_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_PATH = 2'd1,
    REQ_CONN = 2'd2
  } req_e;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_PATH = 2'd1;
  localparam logic [1:0] KIND_CONN = 2'd2;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_COUNT    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_RANGE    = 2'd3;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_EDGE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    T_IDLE,
    T_LCLR,
    T_LEDGE,
    T_QWAIT
  } top_state_e;

  typedef enum logic [3:0] {
    W_IDLE,
    W_CLR,
    W_INIT,
    W_POP,
    W_POPW,
    W_ROWW,
    W_EDGE,
    W_EDGEW,
    W_VISW,
    W_SCAN,
    W_SCANW,
    W_DONE
  } walk_state_e;

  typedef struct packed {
    logic done;
    logic answer;
  } walk_stat_t;

endpackage

FILE: src/csrgr_graph_mem.sv
// row start, degree and edge target memories of the compressed sparse row graph
module csrgr_graph_mem import csrgr_pkg::*; #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096,
  localparam int unsigned NodeW = $clog2(MAX_NODES),
  localparam int unsigned CntW  = NodeW + 1,
  localparam int unsigned EdgeW = $clog2(MAX_EDGES + 1)
) (
  input  logic             clk_i,
  input  logic             row_we_i,
  input  logic             deg_we_i,
  input  logic [NodeW-1:0] node_waddr_i,
  input  logic [EdgeW-1:0] row_wdata_i,
  input  logic [EdgeW-1:0] deg_wdata_i,
  input  logic             edge_we_i,
  input  logic [EdgeW-1:0] edge_waddr_i,
  input  logic [CntW-1:0]  edge_wdata_i,
  input  logic [NodeW-1:0] node_raddr_i,
  output logic [EdgeW-1:0] row_rdata_o,
  output logic [EdgeW-1:0] deg_rdata_o,
  input  logic [EdgeW-1:0] edge_raddr_i,
  output logic [CntW-1:0]  edge_rdata_o
);

  logic [EdgeW-1:0] row_mem  [MAX_NODES];
  logic [EdgeW-1:0] deg_mem  [MAX_NODES];
  logic [CntW-1:0]  edge_mem [MAX_EDGES + 1];

  always_ff @(posedge clk_i) begin
    if (row_we_i) begin
      row_mem[node_waddr_i] <= row_wdata_i;
    end
    row_rdata_o <= row_mem[node_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (deg_we_i) begin
      deg_mem[node_waddr_i] <= deg_wdata_i;
    end
    deg_rdata_o <= deg_mem[node_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we_i) begin
      edge_mem[edge_waddr_i] <= edge_wdata_i;
    end
    edge_rdata_o <= edge_mem[edge_raddr_i];
  end

endmodule

FILE: src/csrgr_walk.sv
// depth-first walk sequencer with visited map and node stack
module csrgr_walk import csrgr_pkg::*; #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096,
  localparam int unsigned NodeW = $clog2(MAX_NODES),
  localparam int unsigned CntW  = NodeW + 1,
  localparam int unsigned EdgeW = $clog2(MAX_EDGES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             conn_i,
  input  logic [NodeW-1:0] start_node_i,
  input  logic [CntW-1:0]  target_i,
  input  logic [CntW-1:0]  nn_i,
  output logic [NodeW-1:0] node_raddr_o,
  input  logic [EdgeW-1:0] row_rdata_i,
  input  logic [EdgeW-1:0] deg_rdata_i,
  output logic [EdgeW-1:0] edge_raddr_o,
  input  logic [CntW-1:0]  edge_rdata_i,
  output walk_stat_t       stat_o
);

  localparam logic [CntW-1:0]  LastIdx  = CntW'(MAX_NODES - 1);
  localparam logic [EdgeW:0]   MaxEdgeC = (EdgeW + 1)'(MAX_EDGES);

  walk_state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  sp_q, sp_d;
  logic [EdgeW:0]   e_q, e_d;
  logic [EdgeW-1:0] left_q, left_d;
  logic [NodeW-1:0] d_q, d_d;
  logic             found_q, found_d;
  logic             all_q, all_d;
  logic             conn_q, conn_d;
  logic [CntW-1:0]  target_q, target_d;
  logic [CntW-1:0]  nn_q, nn_d;
  logic [NodeW-1:0] start_q, start_d;

  logic             vis_mem [MAX_NODES];
  logic             vis_rdata_q;
  logic             vis_we, vis_wdata;
  logic [NodeW-1:0] vis_waddr, vis_raddr;
  logic [NodeW-1:0] stk_mem [MAX_NODES];
  logic [NodeW-1:0] stk_rdata_q;
  logic             stk_we;
  logic [NodeW-1:0] stk_waddr, stk_raddr;
  logic [CntW-1:0]  sp_dec;
  logic             skip_dst;

  assign sp_dec   = sp_q - CntW'(1);
  assign skip_dst = edge_rdata_i >= nn_q;

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rdata_q <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= d_q;
    end
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      W_IDLE:  if (start_i) state_d = W_CLR;
      W_CLR:   if (cnt_q == LastIdx) state_d = W_INIT;
      W_INIT:  state_d = W_POP;
      W_POP: begin
        if (sp_q == '0 || found_q) state_d = conn_q ? W_SCAN : W_DONE;
        else state_d = W_POPW;
      end
      W_POPW:  state_d = W_ROWW;
      W_ROWW:  state_d = W_EDGE;
      W_EDGE: begin
        if (found_q || left_q == '0 || e_q > MaxEdgeC) state_d = W_POP;
        else state_d = W_EDGEW;
      end
      W_EDGEW: state_d = skip_dst ? W_EDGE : W_VISW;
      W_VISW:  state_d = W_EDGE;
      W_SCAN:  state_d = (cnt_q == nn_q) ? W_DONE : W_SCANW;
      W_SCANW: state_d = vis_rdata_q ? W_SCAN : W_DONE;
      W_DONE:  state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    sp_d      = sp_q;
    e_d       = e_q;
    left_d    = left_q;
    d_d       = d_q;
    found_d   = found_q;
    all_d     = all_q;
    conn_d    = conn_q;
    target_d  = target_q;
    nn_d      = nn_q;
    start_d   = start_q;
    vis_we    = 1'b0;
    vis_wdata = 1'b0;
    vis_waddr = cnt_q[NodeW-1:0];
    vis_raddr = cnt_q[NodeW-1:0];
    stk_we    = 1'b0;
    stk_waddr = sp_q[NodeW-1:0];
    stk_raddr = sp_dec[NodeW-1:0];
    unique case (state_q)
      W_IDLE: begin
        if (start_i) begin
          cnt_d    = '0;
          found_d  = 1'b0;
          conn_d   = conn_i;
          target_d = target_i;
          nn_d     = nn_i;
          start_d  = start_node_i;
          d_d      = start_node_i;
        end
      end
      W_CLR: begin
        vis_we = 1'b1;
        cnt_d  = cnt_q + CntW'(1);
      end
      W_INIT: begin
        vis_we    = 1'b1;
        vis_wdata = 1'b1;
        vis_waddr = start_q;
        stk_we    = 1'b1;
        stk_waddr = '0;
        sp_d      = CntW'(1);
      end
      W_POP: begin
        if (sp_q == '0 || found_q) begin
          cnt_d = '0;
          all_d = 1'b1;
        end else begin
          sp_d = sp_dec;
        end
      end
      W_ROWW: begin
        e_d    = {1'b0, row_rdata_i};
        left_d = deg_rdata_i;
      end
      W_EDGEW: begin
        if (skip_dst) begin
          e_d    = e_q + (EdgeW + 1)'(1);
          left_d = left_q - EdgeW'(1);
        end else begin
          if (edge_rdata_i == target_q) found_d = 1'b1;
          vis_raddr = edge_rdata_i[NodeW-1:0];
          d_d       = edge_rdata_i[NodeW-1:0];
        end
      end
      W_VISW: begin
        // first sighting of this node: mark and push
        if (!vis_rdata_q) begin
          vis_we    = 1'b1;
          vis_wdata = 1'b1;
          vis_waddr = d_q;
          stk_we    = 1'b1;
          sp_d      = sp_q + CntW'(1);
        end
        e_d    = e_q + (EdgeW + 1)'(1);
        left_d = left_q - EdgeW'(1);
      end
      W_SCANW: begin
        if (!vis_rdata_q) all_d = 1'b0;
        else cnt_d = cnt_q + CntW'(1);
      end
      default: ;
    endcase
  end

  assign node_raddr_o  = stk_rdata_q;
  assign edge_raddr_o  = e_q[EdgeW-1:0];
  assign stat_o.done   = state_q == W_DONE;
  assign stat_o.answer = conn_q ? all_q : found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      found_q <= 1'b0;
      all_q   <= 1'b0;
      conn_q  <= 1'b0;
      sp_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      all_q   <= all_d;
      conn_q  <= conn_d;
      sp_q    <= sp_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q      <= e_d;
    left_q   <= left_d;
    d_q      <= d_d;
    target_q <= target_d;
    nn_q     <= nn_d;
    start_q  <= start_d;
  end

endmodule

FILE: src/csr_graph_reachability.sv
// Compressed sparse row graph store with depth-first path and connectivity
// queries. After reset the degree memory is swept to zero before the first
// transfer is taken. Each later edge of a load run is stored as it is taken;
// the first edge of a run first sweeps the degree memory, then stores the
// edge from the T_LEDGE state. A query clears the visited map, then the walk
// reads the row start and degree of each popped node, the target of each
// stored edge and, when the destination is not skipped, its visited bit,
// through memories with one write and one read port each; a connectivity
// query ends with a final visited scan. The result register lets a new
// transfer be taken in the cycle its predecessor's result leaves.
module csr_graph_reachability import csrgr_pkg::*; #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096,
  localparam int unsigned NodeW = $clog2(MAX_NODES),
  localparam int unsigned CntW  = NodeW + 1,
  localparam int unsigned EdgeW = $clog2(MAX_EDGES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       req_type_i,
  input  logic [NodeW-1:0] src_node_i,
  input  logic [CntW-1:0]  dst_node_i,
  input  logic             last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic             answer_o,
  output logic [1:0]       error_code_o
);

  localparam logic [CntW-1:0]  MaxNodesC = CntW'(MAX_NODES);
  localparam logic [CntW-1:0]  LastIdx   = CntW'(MAX_NODES - 1);
  localparam logic [EdgeW-1:0] MaxEdgesC = EdgeW'(MAX_EDGES);

  top_state_e state_q, state_d;
  logic [CntW-1:0]  node_count_q;
  logic [EdgeW-1:0] edge_count_q;
  logic [CntW-1:0]  nn;

  logic [1:0]       req_q, req_d;
  logic [NodeW-1:0] src_q, src_d;
  logic [CntW-1:0]  dst_q, dst_d;
  logic             last_q, last_d;
  logic             loading_q, loading_d;
  logic [EdgeW-1:0] edges_q, edges_d;
  logic [NodeW-1:0] prev_q, prev_d;
  logic [EdgeW-1:0] cur_deg_q, cur_deg_d;
  logic [1:0]       err_q, err_d;
  logic [CntW-1:0]  clr_q, clr_d;
  logic             boot_q, boot_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       kind_q, kind_d;
  logic             ans_q, ans_d;
  logic [1:0]       code_q, code_d;

  logic             acc, cfg_wr;
  logic [1:0]       it_req;
  logic [NodeW-1:0] it_src;
  logic [CntW-1:0]  it_dst;
  logic             it_last;
  logic             edge_go, bad_edge, store_full, same_src;
  logic [EdgeW-1:0] slot, deg_new;

  logic             row_we, deg_we, edge_we;
  logic [NodeW-1:0] node_waddr;
  logic [EdgeW-1:0] row_wdata, deg_wdata;
  logic             walk_start, walk_conn;
  logic [NodeW-1:0] walk_node;
  logic [CntW-1:0]  walk_target;
  logic [NodeW-1:0] node_raddr;
  logic [EdgeW-1:0] row_rdata, deg_rdata, edge_raddr;
  logic [CntW-1:0]  edge_rdata;
  walk_stat_t       wstat;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= MaxNodesC;
      edge_count_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NODE_COUNT: node_count_q <= pwdata[CntW-1:0];
        REG_EDGE_COUNT: edge_count_q <= pwdata[EdgeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NODE_COUNT: prdata = 32'(node_count_q);
      REG_EDGE_COUNT: prdata = 32'(edge_count_q);
      default:        prdata = '0;
    endcase
  end

  // node count clamped to 1 .. MAX_NODES, also the sentinel
  always_comb begin
    if (node_count_q == '0) nn = CntW'(1);
    else if (node_count_q > MaxNodesC) nn = MaxNodesC;
    else nn = node_count_q;
  end

  assign in_ready_o = (state_q == T_IDLE) && (!out_valid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;

  assign it_req  = (state_q == T_LEDGE) ? req_q  : req_type_i;
  assign it_src  = (state_q == T_LEDGE) ? src_q  : src_node_i;
  assign it_dst  = (state_q == T_LEDGE) ? dst_q  : dst_node_i;
  assign it_last = (state_q == T_LEDGE) ? last_q : last_i;

  assign edge_go    = (acc && it_req == REQ_LOAD && loading_q) || state_q == T_LEDGE;
  assign bad_edge   = (CntW'(it_src) >= nn) || (it_dst > nn);
  assign store_full = edges_q >= MaxEdgesC;
  assign same_src   = it_src == prev_q;
  assign slot       = edges_q + EdgeW'(1);
  assign deg_new    = same_src ? cur_deg_q + EdgeW'(1) : EdgeW'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (acc) begin
          case (it_req)
            REQ_LOAD: if (!loading_q) state_d = T_LCLR;
            REQ_PATH: begin
              if (!((CntW'(it_src) >= nn) || (it_dst >= nn))) state_d = T_QWAIT;
            end
            REQ_CONN: state_d = T_QWAIT;
            default: ;
          endcase
        end
      end
      // the sweep after reset has no edge waiting behind it
      T_LCLR:  if (clr_q == LastIdx) state_d = boot_q ? T_IDLE : T_LEDGE;
      T_LEDGE: state_d = T_IDLE;
      T_QWAIT: if (wstat.done) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    req_d       = req_q;
    src_d       = src_q;
    dst_d       = dst_q;
    last_d      = last_q;
    loading_d   = loading_q;
    edges_d     = edges_q;
    prev_d      = prev_q;
    cur_deg_d   = cur_deg_q;
    err_d       = err_q;
    clr_d       = clr_q;
    boot_d      = boot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    ans_d       = ans_q;
    code_d      = code_q;
    row_we      = 1'b0;
    deg_we      = 1'b0;
    edge_we     = 1'b0;
    node_waddr  = it_src;
    row_wdata   = slot;
    deg_wdata   = deg_new;
    walk_start  = 1'b0;
    walk_conn   = 1'b0;
    walk_node   = it_src;
    walk_target = it_dst;

    if (acc) begin
      req_d  = req_type_i;
      src_d  = src_node_i;
      dst_d  = dst_node_i;
      last_d = last_i;
      case (it_req)
        REQ_LOAD: begin
          if (!loading_q) begin
            // load start: reset counters, mark row 0, sweep degrees
            loading_d  = 1'b1;
            edges_d    = '0;
            err_d      = ERR_OK;
            prev_d     = '0;
            cur_deg_d  = '0;
            clr_d      = '0;
            row_we     = 1'b1;
            node_waddr = '0;
            row_wdata  = EdgeW'(1);
          end
        end
        REQ_PATH: begin
          if ((CntW'(it_src) >= nn) || (it_dst >= nn)) begin
            out_valid_d = 1'b1;
            kind_d      = KIND_PATH;
            ans_d       = 1'b0;
            code_d      = ERR_RANGE;
          end else begin
            walk_start = 1'b1;
          end
        end
        REQ_CONN: begin
          walk_start  = 1'b1;
          walk_conn   = 1'b1;
          walk_node   = '0;
          walk_target = nn;
        end
        default: ;
      endcase
    end

    if (state_q == T_LCLR) begin
      deg_we     = 1'b1;
      deg_wdata  = '0;
      node_waddr = clr_q[NodeW-1:0];
      clr_d      = clr_q + CntW'(1);
      if (clr_q == LastIdx) boot_d = 1'b0;
    end

    if (edge_go) begin
      if (bad_edge) begin
        if (err_q == ERR_OK) err_d = ERR_RANGE;
      end else if (store_full) begin
        if (err_q == ERR_OK) err_d = ERR_OVERFLOW;
      end else begin
        edge_we = 1'b1;
        deg_we  = 1'b1;
        edges_d = slot;
        cur_deg_d = deg_new;
        if (!same_src) begin
          row_we = 1'b1;
          prev_d = it_src;
        end
      end
      if (it_last) begin
        out_valid_d = 1'b1;
        kind_d      = KIND_LOAD;
        ans_d       = 1'b0;
        if (err_d != ERR_OK) code_d = err_d;
        else code_d = (edges_d != edge_count_q) ? ERR_COUNT : ERR_OK;
        loading_d   = 1'b0;
      end
    end

    if (state_q == T_QWAIT && wstat.done) begin
      out_valid_d = 1'b1;
      kind_d      = (req_q == REQ_CONN) ? KIND_CONN : KIND_PATH;
      ans_d       = wstat.answer;
      code_d      = ERR_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_LCLR;
      loading_q   <= 1'b0;
      edges_q     <= '0;
      prev_q      <= '0;
      cur_deg_q   <= '0;
      err_q       <= ERR_OK;
      clr_q       <= '0;
      boot_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loading_q   <= loading_d;
      edges_q     <= edges_d;
      prev_q      <= prev_d;
      cur_deg_q   <= cur_deg_d;
      err_q       <= err_d;
      clr_q       <= clr_d;
      boot_q      <= boot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    src_q  <= src_d;
    dst_q  <= dst_d;
    last_q <= last_d;
    kind_q <= kind_d;
    ans_q  <= ans_d;
    code_q <= code_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign answer_o      = ans_q;
  assign error_code_o  = code_q;

  csrgr_graph_mem #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_graph (
    .clk_i        (clk_i),
    .row_we_i     (row_we),
    .deg_we_i     (deg_we),
    .node_waddr_i (node_waddr),
    .row_wdata_i  (row_wdata),
    .deg_wdata_i  (deg_wdata),
    .edge_we_i    (edge_we),
    .edge_waddr_i (slot),
    .edge_wdata_i (it_dst),
    .node_raddr_i (node_raddr),
    .row_rdata_o  (row_rdata),
    .deg_rdata_o  (deg_rdata),
    .edge_raddr_i (edge_raddr),
    .edge_rdata_o (edge_rdata)
  );

  csrgr_walk #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (walk_start),
    .conn_i       (walk_conn),
    .start_node_i (walk_node),
    .target_i     (walk_target),
    .nn_i         (nn),
    .node_raddr_o (node_raddr),
    .row_rdata_i  (row_rdata),
    .deg_rdata_i  (deg_rdata),
    .edge_raddr_o (edge_raddr),
    .edge_rdata_i (edge_rdata),
    .stat_o       (wstat)
  );

  a_walk_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wstat.done |-> state_q == T_QWAIT)
    else $error("walk finished while no query was pending");

  a_load_answer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_LOAD) |-> !ans_q)
    else $error("load status carries a nonzero answer");

  a_conn_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_CONN) |-> code_q == ERR_OK)
    else $error("connectivity answer carries an error");

  a_edges_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edges_q <= MaxEdgesC)
    else $error("edge store count beyond capacity");

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_start |=> state_q == T_QWAIT)
    else $error("query transfer did not wait for the walk");

endmodule
